/* hw/rtl/lzrw_pkg.sv */
// Shared constants for the LZ run window decoder.
// No dependencies; used by the top level, the window memory, the checker and the testbench.
package lzrw_pkg;

    // Ring window depth (one byte per entry)
    localparam int WINDOW_DEPTH = 256;

    // Header byte fields
    localparam logic [7:0] HDR_COUNT_MASK = 8'h7f;
    localparam logic [7:0] HDR_COPY_FLAG  = 8'h80;

    // Bytes carried by one result
    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;

endpackage

/* hw/rtl/lz_run_window_decoder_unit.sv */
// LZ run window decoder top level: token parser, copy sequencer, output register.
// Depends on lzrw_pkg and lzrw_window.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, data_byte, start_stream      | consumed
//  out     | out_valid, out_stall, byte_first, byte_second,   | produced
//          | byte_count, run_last, stream_end                 |
//
// A literal byte needs the output register free. A copy run of N bytes holds
// the input after the distance byte until its last byte is written: each byte
// is a read then a write, through the window's read and write ports in turn.
// Reset clears the window at once through per-entry valid bits; no sweep.
// A stalled output register holds the input, and the copy sequencer when a result is due.
module lz_run_window_decoder_unit #(
    parameter int WINDOW_DEPTH = lzrw_pkg::WINDOW_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       start_stream,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] byte_first,
    output logic [7:0] byte_second,
    output logic [1:0] byte_count,
    output logic       run_last,
    output logic       stream_end
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_LITERAL,
        PH_DISTANCE,
        PH_ENDED
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_WR
    } ctl_t;

    phase_t        phase_reg, phase_next, eff_phase;
    ctl_t          ctl_reg, ctl_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [6:0]    rem_reg, rem_next;
    logic [7:0]    dist_reg, dist_next;
    logic [6:0]    cnt_reg, cnt_next;
    logic          half_reg, half_next;
    logic [7:0]    hold_reg, hold_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    first_reg, first_next;
    logic [7:0]    second_reg, second_next;
    logic [1:0]    count_reg, count_next;
    logic          last_reg, last_next;
    logic          end_reg, end_next;

    logic          in_xfer;
    logic          out_free;
    logic          emit_now;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    copy_byte;

    // Handshake
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (ctl_reg != ST_IDLE) || !out_free;
    assign in_xfer  = in_valid && !in_stall;

    // Restart forces header parsing at position zero
    assign eff_phase = start_stream ? PH_HEADER : phase_reg;

    // Copy source is head minus distance, wrapping around the ring
    assign rd_en    = (ctl_reg == ST_RD);
    assign rd_addr  = wp_reg - dist_reg[AW-1:0];
    assign emit_now = half_reg || (cnt_reg == 7'd1);

    lzrw_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (copy_byte)
    );

    // Parser, copy sequencer and output load
    always_comb
    begin
        phase_next     = phase_reg;
        ctl_next       = ctl_reg;
        wp_next        = wp_reg;
        rem_next       = rem_reg;
        dist_next      = dist_reg;
        cnt_next       = cnt_reg;
        half_next      = half_reg;
        hold_next      = hold_reg;
        out_valid_next = out_valid_reg && out_stall;
        first_next     = first_reg;
        second_next    = second_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        end_next       = end_reg;
        wr_en          = 1'b0;
        wr_addr        = wp_reg;
        wr_data        = data_byte;

        unique case (ctl_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (start_stream)
                    begin
                        wp_next    = '0;
                        rem_next   = 7'd0;
                        phase_next = PH_HEADER;
                    end
                    unique case (eff_phase)
                        PH_HEADER:
                        begin
                            if (data_byte == 8'h00)
                            begin
                                phase_next     = PH_ENDED;
                                rem_next       = 7'd0;
                                out_valid_next = 1'b1;
                                first_next     = 8'h00;
                                second_next    = 8'h00;
                                count_next     = lzrw_pkg::CNT_NONE;
                                last_next      = 1'b1;
                                end_next       = 1'b1;
                            end
                            else
                            begin
                                rem_next = 7'(data_byte & lzrw_pkg::HDR_COUNT_MASK);
                                if ((data_byte & lzrw_pkg::HDR_COPY_FLAG) != 8'h00)
                                begin
                                    phase_next = PH_DISTANCE;
                                end
                                else
                                begin
                                    phase_next = PH_LITERAL;
                                end
                            end
                        end
                        PH_LITERAL:
                        begin
                            wr_en          = 1'b1;
                            wp_next        = wp_reg + 1'b1;
                            out_valid_next = 1'b1;
                            first_next     = data_byte;
                            second_next    = 8'h00;
                            count_next     = lzrw_pkg::CNT_ONE;
                            last_next      = 1'b1;
                            end_next       = 1'b0;
                            rem_next       = rem_reg - 7'd1;
                            if (rem_reg == 7'd1)
                            begin
                                phase_next = PH_HEADER;
                            end
                        end
                        PH_DISTANCE:
                        begin
                            rem_next   = 7'd0;
                            phase_next = PH_HEADER;
                            // zero-length copy just consumes the distance
                            if (rem_reg != 7'd0)
                            begin
                                dist_next = data_byte;
                                cnt_next  = rem_reg;
                                half_next = 1'b0;
                                ctl_next  = ST_RD;
                            end
                        end
                        PH_ENDED:
                        begin
                            // bytes after the end are dropped
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                ctl_next = ST_WR;
            end
            ST_WR:
            begin
                // wait for the output register only when a result is due
                if (!emit_now || out_free)
                begin
                    wr_en    = 1'b1;
                    wr_data  = copy_byte;
                    wp_next  = wp_reg + 1'b1;
                    cnt_next = cnt_reg - 7'd1;
                    if (emit_now)
                    begin
                        out_valid_next = 1'b1;
                        first_next     = half_reg ? hold_reg : copy_byte;
                        second_next    = half_reg ? copy_byte : 8'h00;
                        count_next     = half_reg ? lzrw_pkg::CNT_TWO : lzrw_pkg::CNT_ONE;
                        last_next      = (cnt_reg == 7'd1);
                        end_next       = 1'b0;
                        half_next      = 1'b0;
                    end
                    else
                    begin
                        hold_next = copy_byte;
                        half_next = 1'b1;
                    end
                    ctl_next = (cnt_reg == 7'd1) ? ST_IDLE : ST_RD;
                end
            end
            default:
            begin
                ctl_next = ST_IDLE;
            end
        endcase
    end

    // Control state, copy payload and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            ctl_reg       <= ST_IDLE;
            wp_reg        <= '0;
            rem_reg       <= 7'd0;
            dist_reg      <= 8'h00;
            cnt_reg       <= 7'd0;
            half_reg      <= 1'b0;
            hold_reg      <= 8'h00;
            out_valid_reg <= 1'b0;
            first_reg     <= 8'h00;
            second_reg    <= 8'h00;
            count_reg     <= lzrw_pkg::CNT_NONE;
            last_reg      <= 1'b0;
            end_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            ctl_reg       <= ctl_next;
            wp_reg        <= wp_next;
            rem_reg       <= rem_next;
            dist_reg      <= dist_next;
            cnt_reg       <= cnt_next;
            half_reg      <= half_next;
            hold_reg      <= hold_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            end_reg       <= end_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_first  = first_reg;
    assign byte_second = second_reg;
    assign byte_count  = count_reg;
    assign run_last    = last_reg;
    assign stream_end  = end_reg;

endmodule

/* hw/rtl/lzrw_window.sv */
// Ring window memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset.
// Depends on lzrw_pkg for the default depth.
module lzrw_window #(
    parameter int WINDOW_DEPTH = lzrw_pkg::WINDOW_DEPTH,
    localparam int AW = $clog2(WINDOW_DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0]              mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] vld_reg;
    logic [7:0]              rd_data_reg;
    logic                    rd_vld_reg;

    // Data array, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // Never-written entry reads as zero
    assign rd_data = rd_vld_reg ? rd_data_reg : 8'h00;

endmodule

/* hw/rtl/lzrw_checker.sv */
// Port-level checker for the LZ run window decoder, bound to the top level.
// Depends on lzrw_pkg for result byte counts.
module lzrw_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] data_byte,
    input logic       start_stream,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] byte_first,
    input logic [7:0] byte_second,
    input logic [1:0] byte_count,
    input logic       run_last,
    input logic       stream_end
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(byte_first)
            && $stable(byte_second) && $stable(byte_count)
            && $stable(run_last) && $stable(stream_end))
        else $error("stalled result changed");

    // End marker carries no bytes and closes its run
    a_end_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stream_end |-> byte_count == lzrw_pkg::CNT_NONE && run_last)
        else $error("end result malformed");

    // Only the last result of a run may carry fewer than two bytes
    a_short_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_count != lzrw_pkg::CNT_TWO |-> run_last)
        else $error("short result before end of run");

    // Restart with a zero header ends the stream on the next cycle
    a_restart_end: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && start_stream && data_byte == 8'h00
            |=> out_valid && stream_end)
        else $error("zero header did not end the stream");

endmodule

bind lz_run_window_decoder_unit lzrw_checker u_lzrw_checker (.*);

/* verif/tb_lz_run_window_decoder_unit.sv */
// Self-checking testbench for lz_run_window_decoder_unit: directed and random token
// streams, a bit-accurate decode predictor and an in-order result scoreboard.
// Depends on lzrw_pkg and the decoder RTL.
module tb_lz_run_window_decoder_unit;

    localparam int CLK_HALF    = 4;
    localparam int RESET_CYC   = 10;
    localparam int RANDOM_ITEMS = 450;
    localparam int TAIL_CYC    = 300;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 60;

    typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_DISTANCE, PH_ENDED} parse_phase_t;

    typedef struct {
        logic [7:0] data;
        logic       start;
        bit         hold;
    } token_byte_t;

    typedef struct {
        logic [7:0] first;
        logic [7:0] second;
        logic [1:0] count;
        logic       last;
        logic       done;
    } decoded_pair_t;

    // DUT connections
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       start_stream = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [1:0] byte_count;
    logic       run_last;
    logic       stream_end;

    // Stimulus and scoreboard storage
    token_byte_t   token_q[$];
    decoded_pair_t decoded_q[$];

    // Predictor state
    logic [7:0]   win_mem [0:lzrw_pkg::WINDOW_DEPTH-1];
    logic [7:0]   wr_pos;
    parse_phase_t phase;
    logic [6:0]   run_left;

    // Generator bookkeeping
    int  live_count = 0;
    bit  restart_next = 1'b0;
    bit  hold_next = 1'b0;

    // Driver / receiver state
    bit  in_taken = 1'b0;
    bit  drv_next;
    int  burst_left = 1;
    int  gap_left = 0;
    int  stall_mode = 0;
    int  stall_left = 0;
    bit  stall_next;
    token_byte_t drv_item;

    int  err_count = 0;
    int  cycle_count = 0;

    lz_run_window_decoder_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .start_stream (start_stream),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_first   (byte_first),
        .byte_second  (byte_second),
        .byte_count   (byte_count),
        .run_last     (run_last),
        .stream_end   (stream_end)
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // One line per mismatch; printing is capped, counting is not
    task automatic report_mismatch(input string msg);
        if (err_count < MAX_PRINTS)
            $display("ERROR cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // Predictor: consume one accepted stream byte, queue the results it causes
    task automatic decode_token_byte(input logic [7:0] d, input logic st);
        decoded_pair_t r;
        logic [7:0]    src;
        logic [7:0]    v;
        int            n;
        int            k;
        if (st)
        begin
            wr_pos   = 8'h00;
            phase    = PH_HEADER;
            run_left = 7'd0;
        end
        case (phase)
            PH_HEADER:
            begin
                if (d == 8'h00)
                begin
                    phase    = PH_ENDED;
                    run_left = 7'd0;
                    r = '{first: 8'h00, second: 8'h00, count: lzrw_pkg::CNT_NONE,
                          last: 1'b1, done: 1'b1};
                    decoded_q.push_back(r);
                end
                else
                begin
                    run_left = 7'(d & lzrw_pkg::HDR_COUNT_MASK);
                    phase    = ((d & lzrw_pkg::HDR_COPY_FLAG) != 8'h00) ? PH_DISTANCE
                                                                        : PH_LITERAL;
                end
            end
            PH_LITERAL:
            begin
                win_mem[wr_pos] = d;
                wr_pos = wr_pos + 8'd1;
                r = '{first: d, second: 8'h00, count: lzrw_pkg::CNT_ONE,
                      last: 1'b1, done: 1'b0};
                decoded_q.push_back(r);
                run_left = run_left - 7'd1;
                if (run_left == 7'd0)
                    phase = PH_HEADER;
            end
            PH_DISTANCE:
            begin
                n = run_left;
                while (n > 0)
                begin
                    r = '{first: 8'h00, second: 8'h00, count: lzrw_pkg::CNT_NONE,
                          last: 1'b0, done: 1'b0};
                    k = 0;
                    while (k < 2 && n > 0)
                    begin
                        // byte by byte, so overlapping copies see fresh data
                        src = wr_pos - d;
                        v   = win_mem[src];
                        win_mem[wr_pos] = v;
                        wr_pos = wr_pos + 8'd1;
                        if (k == 0)
                            r.first = v;
                        else
                            r.second = v;
                        k++;
                        n--;
                    end
                    r.count = (k == 1) ? lzrw_pkg::CNT_ONE : lzrw_pkg::CNT_TWO;
                    r.last  = (n == 0);
                    decoded_q.push_back(r);
                end
                run_left = 7'd0;
                phase    = PH_HEADER;
            end
            default:
            begin
                // ended: ignored until a restart
            end
        endcase
    endtask

    // Stimulus construction
    task automatic push_byte(input logic [7:0] d, input logic st, input bit counted);
        token_byte_t t;
        t.data  = d;
        t.start = st;
        t.hold  = hold_next;
        hold_next = 1'b0;
        token_q.push_back(t);
        if (counted)
            live_count++;
    endtask

    task automatic push_header(input logic [7:0] h);
        push_byte(h, restart_next, 1'b1);
        restart_next = 1'b0;
    endtask

    task automatic add_literal_run(input int len);
        int i;
        push_header({1'b0, 7'(len)});
        for (i = 0; i < len; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic add_copy_run(input int len, input logic [7:0] dist_byte);
        push_header({1'b1, 7'(len)});
        push_byte(dist_byte, 1'b0, 1'b1);
    endtask

    task automatic build_directed;
        // literal run with byte extremes
        push_byte(8'h03, 1'b1, 1'b1);
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'hff, 1'b0, 1'b1);
        push_byte(8'h5a, 1'b0, 1'b1);
        // overlapping copy: length beyond distance
        add_copy_run(4, 8'h03);
        // zero-length copy consumes the distance silently
        add_copy_run(0, 8'h11);
        // distance zero re-emits old window contents
        add_copy_run(3, 8'h00);
        // longest copy run
        add_copy_run(127, 8'h01);
        add_literal_run(1);
        add_copy_run(1, 8'hff);
        // drain fully, then end the stream
        hold_next = 1'b1;
        push_header(8'h00);
        // bytes after the end are ignored
        push_byte(8'h37, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        // restart straight into another end
        push_byte(8'h00, 1'b1, 1'b1);
        // restart in the middle of a literal run
        push_byte(8'h02, 1'b1, 1'b1);
        push_byte(8'h12, 1'b0, 1'b1);
        push_byte(8'h81, 1'b1, 1'b1);
        push_byte(8'hc3, 1'b0, 1'b1);
    endtask

    task automatic build_random;
        int target;
        int sel;
        int len;
        int i;
        logic [7:0] dist_byte;
        target = live_count + RANDOM_ITEMS;
        // longest literal run once
        add_literal_run(127);
        while (live_count < target)
        begin
            if ($urandom_range(0, 49) == 0)
                hold_next = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 8);
                add_literal_run(len);
            end
            else if (sel < 80)
            begin
                len  = ($urandom_range(0, 24) == 0) ? $urandom_range(0, 127)
                                                    : $urandom_range(0, 12);
                dist_byte = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 4))
                                                        : 8'($urandom_range(0, 255));
                add_copy_run(len, dist_byte);
            end
            else if (sel < 86)
            begin
                // end of stream, a few ignored bytes, then restart
                push_header(8'h00);
                len = $urandom_range(0, 3);
                for (i = 0; i < len; i++)
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                restart_next = 1'b1;
            end
            else if (sel < 92)
            begin
                // broken run cut short by a restart
                if ($urandom_range(0, 1) == 0)
                begin
                    push_header({1'b0, 7'($urandom_range(3, 20))});
                    push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                end
                else
                    push_header({1'b1, 7'($urandom_range(1, 20))});
                restart_next = 1'b1;
            end
            else
            begin
                // raw noise
                push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end
        end
    endtask

    // Sender: bursts with gaps, new payload only after a transfer
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            drv_next = 1'b0;
            if (gap_left != 0)
            begin
                gap_left--;
            end
            else if (token_q.size() != 0 && !(token_q[0].hold && decoded_q.size() != 0))
            begin
                drv_item = token_q.pop_front();
                data_byte    <= drv_item.data;
                start_stream <= drv_item.start;
                drv_next = 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            in_valid <= drv_next;
        end
    end

    // Receiver: stall pattern switches mode every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(32, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       stall_next = 1'b0;
            1:       stall_next = ($urandom_range(0, 3) == 0);
            2:       stall_next = ($urandom_range(0, 1) == 0);
            default: stall_next = ($urandom_range(0, 9) != 0);
        endcase
        out_stall <= stall_next;
    end

    // Monitor: check result transfers, then predict from input transfers
    always @(posedge clk)
    begin
        decoded_pair_t w;
        in_taken = 1'b0;
        if (rst_n)
        begin
            cycle_count++;
            if (out_valid && !out_stall)
            begin
                if (decoded_q.size() == 0)
                    report_mismatch($sformatf("result with nothing expected: %h %h cnt=%0d",
                                              byte_first, byte_second, byte_count));
                else
                begin
                    w = decoded_q.pop_front();
                    if (byte_first !== w.first)
                        report_mismatch($sformatf("byte_first %h want %h", byte_first, w.first));
                    if (byte_second !== w.second)
                        report_mismatch($sformatf("byte_second %h want %h",
                                                  byte_second, w.second));
                    if (byte_count !== w.count)
                        report_mismatch($sformatf("byte_count %0d want %0d",
                                                  byte_count, w.count));
                    if (run_last !== w.last)
                        report_mismatch($sformatf("run_last %b want %b", run_last, w.last));
                    if (stream_end !== w.done)
                        report_mismatch($sformatf("stream_end %b want %b", stream_end, w.done));
                end
            end
            if (in_valid && !in_stall)
            begin
                in_taken = 1'b1;
                decode_token_byte(data_byte, start_stream);
            end
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("tb_lz_run_window_decoder_unit NOT OK");
                $finish;
            end
        end
    end

    // Sequence: build stimulus, reset, run to drain, judge
    initial
    begin
        int i;
        for (i = 0; i < lzrw_pkg::WINDOW_DEPTH; i++)
            win_mem[i] = 8'h00;
        wr_pos   = 8'h00;
        phase    = PH_HEADER;
        run_left = 7'd0;

        build_directed();
        build_random();

        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (token_q.size() != 0 || in_valid)
            @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYC) @(posedge clk);

        if (decoded_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
        if (err_count == 0)
            $display("tb_lz_run_window_decoder_unit OK");
        else
            $display("tb_lz_run_window_decoder_unit NOT OK");
        $finish;
    end

endmodule
